/* rtl/core/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/pbp_pkg.sv */
// shared types and constants of the bezier path block
package pbp_pkg;
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_EVAL  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,      // latch input word
        CMD_RD_LAST,   // read last point
        CMD_PUT_MID,   // write midpoint
        CMD_PUT_NEW,   // write new point
        CMD_RD_P0,
        CMD_RD_P1,
        CMD_PUT_REFL,
        CMD_PUT_P0,
        CMD_SEGCNT,    // recompute segment count
        CMD_CLEAR,
        CMD_DIV_STEP,  // one bit of segment modulo
        CMD_WEIGHT,    // weight products
        CMD_BLEND_RD,  // read blend point
        CMD_BLEND_ACC, // accumulate one product
        CMD_FINISH,
        CMD_DROP       // mark operation as dropped
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_LAST, S_MID, S_NEW, S_SEG,
        S_RD_P0, S_RD_P1, S_REFL, S_P0, S_DIV, S_WEIGHT,
        S_BRD, S_BACC, S_FIN, S_OUT
    } state_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic [1:0] op;
        logic       mid;       // add needs midpoint
        logic       close_go;  // close meets condition
        logic       no_room;   // operation dropped
        logic       few;       // fewer than four points
        logic       div_done;
        logic       blend_done;
    } stat_t;
endpackage

/* rtl/core/pbp_datapath.sv */
// point store, segment modulo and bernstein blend datapath
module pbp_datapath #(
    parameter int MAX_POINTS = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pbp_pkg::ctl_t       ctl,
    output pbp_pkg::stat_t      stat,
    input  logic [1:0]          operation,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [30:0]         path_time,
    output logic signed [31:0]  res_x,
    output logic signed [31:0]  res_y,
    output logic signed [31:0]  res_z,
    output logic [1:0]          res_status
);
    import pbp_pkg::*;

    localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [31:0] mem_z [MAX_POINTS];

    logic [1:0]         op_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [30:0]        tm_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_div3_reg;               // point count / 3
    logic [1:0]         cnt_mod3_reg;               // point count mod 3
    logic [CW-1:0]      seg_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;     // registered read data
    logic signed [31:0] ax_reg, ay_reg, az_reg;     // held p0
    logic [14:0]        rem_reg;                    // modulo remainder
    logic [14:0]        quo_reg;                    // dividend shifting out
    logic [3:0]         dbit_reg;
    logic [16:0]        u_reg, t_reg;
    logic [33:0]        uu_reg, tt_reg;
    logic [31:0]        w_reg [4];
    logic [1:0]         bi_reg;
    logic               bvalid_reg;
    logic               drop_reg;
    logic signed [65:0] accx_reg, accy_reg, accz_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [1:0]         ost_reg;
    logic [1:0]         wph_reg;

    // status to controller
    logic mid;
    logic close_go;
    logic no_room;
    always_comb
    begin
        mid      = (cnt_reg != '0) && (cnt_mod3_reg == 2'd0);
        close_go = (cnt_reg >= CW'(2)) && (cnt_mod3_reg == 2'd2);
        no_room  = 1'b0;
        if (op_reg == OP_ADD)
            no_room = ({1'b0, cnt_reg} + (mid ? (CW+1)'(2) : (CW+1)'(1))) > {1'b0, MAXP};
        else if (op_reg == OP_CLOSE)
            no_room = close_go && (({1'b0, cnt_reg} + (CW+1)'(2)) > {1'b0, MAXP});
    end
    assign stat.op         = op_reg;
    assign stat.mid        = mid;
    assign stat.close_go   = close_go;
    assign stat.no_room    = no_room;
    assign stat.few        = cnt_reg < CW'(4);
    assign stat.div_done   = dbit_reg == 4'd0;
    assign stat.blend_done = bi_reg == 2'd3;

    // helpers
    function automatic logic signed [31:0] half_fl(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return s[32:1];
    endfunction

    function automatic logic signed [31:0] refl(logic signed [31:0] a,
                                                logic signed [31:0] b);
        logic signed [33:0] s;
        s = (34'(a) <<< 1) - 34'(b);
        if (s > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -34'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] rnd_sat(logic signed [65:0] a);
        logic signed [65:0] q;
        q = (a + 66'sd536870912) >>> 30;
        if (q > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (q < -66'sd2147483648)
            return 32'sh80000000;
        return q[31:0];
    endfunction

    // address mux, blend index from segment remainder
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic signed [31:0] wx, wy, wz;
    logic [CW-1:0] bidx;
    logic [CW+1:0] bidx_w;
    always_comb
    begin
        bidx_w = (CW+2)'(rem_reg) * (CW+2)'(3) + (CW+2)'(bi_reg);
        bidx   = bidx_w[CW-1:0];
        rd_addr = '0;
        wr_addr = cnt_reg[AW-1:0];
        wr_en   = 1'b0;
        wx = px_reg; wy = py_reg; wz = pz_reg;
        case (ctl.cmd)
            CMD_RD_LAST: rd_addr = AW'(cnt_reg - 1'b1);
            CMD_RD_P0:   rd_addr = '0;
            CMD_RD_P1:   rd_addr = AW'(1);
            CMD_BLEND_RD: rd_addr = bidx[AW-1:0];
            CMD_PUT_MID:
            begin
                wr_en = 1'b1;
                wx = half_fl(px_reg, rx_reg);
                wy = half_fl(py_reg, ry_reg);
                wz = half_fl(pz_reg, rz_reg);
            end
            CMD_PUT_NEW: wr_en = 1'b1;
            CMD_PUT_REFL:
            begin
                wr_en = 1'b1;
                wx = refl(ax_reg, rx_reg);
                wy = refl(ay_reg, ry_reg);
                wz = refl(az_reg, rz_reg);
            end
            CMD_PUT_P0:
            begin
                wr_en = 1'b1;
                wx = ax_reg; wy = ay_reg; wz = az_reg;
            end
            default: ;
        endcase
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wx;
            mem_y[wr_addr] <= wy;
            mem_z[wr_addr] <= wz;
        end
        rx_reg <= mem_x[rd_addr];
        ry_reg <= mem_y[rd_addr];
        rz_reg <= mem_z[rd_addr];
    end

    // segment count rule
    logic [CW-1:0] seg_next;
    always_comb
    begin
        if (cnt_reg <= CW'(4))
            seg_next = CW'(1);
        else if (op_reg == OP_ADD && cnt_mod3_reg == 2'd0)
            seg_next = cnt_div3_reg - 1'b1;
        else
            seg_next = cnt_div3_reg;
    end

    // control state of datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cnt_div3_reg <= '0;
            cnt_mod3_reg <= '0;
            seg_reg      <= '0;
        end
        else
        begin
            case (ctl.cmd)
                CMD_PUT_MID, CMD_PUT_NEW, CMD_PUT_REFL, CMD_PUT_P0:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_mod3_reg == 2'd2)
                    begin
                        cnt_mod3_reg <= 2'd0;
                        cnt_div3_reg <= cnt_div3_reg + 1'b1;
                    end
                    else
                        cnt_mod3_reg <= cnt_mod3_reg + 1'b1;
                end
                CMD_SEGCNT: seg_reg <= seg_next;
                CMD_CLEAR:
                begin
                    cnt_reg      <= '0;
                    cnt_div3_reg <= '0;
                    cnt_mod3_reg <= '0;
                    seg_reg      <= '0;
                end
                default: ;
            endcase
        end
    end

    // working registers: input word, modulo, weights, blend
    logic [15:0] rem_sh;
    logic [CW:0] seg_ext;
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[14]};
        seg_ext = {1'b0, seg_reg};
    end

    logic signed [65:0] prod_x, prod_y, prod_z;
    logic signed [32:0] wsel;
    always_comb
    begin
        wsel   = {1'b0, w_reg[bi_reg]};
        prod_x = 66'(rx_reg) * 66'(wsel);
        prod_y = 66'(ry_reg) * 66'(wsel);
        prod_z = 66'(rz_reg) * 66'(wsel);
    end

    // cubes and cross terms of the weights
    logic [50:0] w_a, w_b, w_c, w_d;
    always_comb
    begin
        w_a = 51'(uu_reg) * 51'(u_reg);
        w_b = 51'(uu_reg) * 51'(t_reg) * 51'd3;
        w_c = 51'(tt_reg) * 51'(u_reg) * 51'd3;
        w_d = 51'(tt_reg) * 51'(t_reg);
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CMD_LOAD:
            begin
                op_reg <= operation;
                px_reg <= coord_x;
                py_reg <= coord_y;
                pz_reg <= coord_z;
                tm_reg <= path_time;
                rem_reg <= '0;
                quo_reg <= path_time[30:16];
                dbit_reg <= 4'd15;
                wph_reg <= '0;
                drop_reg <= 1'b0;
            end
            CMD_DROP:
            begin
                drop_reg <= 1'b1;
            end
            CMD_RD_P0:
            begin
                rem_reg <= rem_reg;
            end
            CMD_DIV_STEP:
            begin
                // restoring remainder, one dividend bit per cycle
                if (seg_reg == '0)
                begin
                    rem_reg  <= '0;
                    dbit_reg <= 4'd0;
                end
                else
                begin
                    if ({1'b0, rem_sh} >= 17'(seg_ext))
                        rem_reg <= 15'(rem_sh - 16'(seg_ext));
                    else
                        rem_reg <= rem_sh[14:0];
                    quo_reg  <= {quo_reg[13:0], 1'b0};
                    dbit_reg <= dbit_reg - 1'b1;
                end
                t_reg <= {1'b0, tm_reg[15:0]};
                u_reg <= 17'h10000 - {1'b0, tm_reg[15:0]};
            end
            CMD_WEIGHT:
            begin
                // phase 0 squares, phase 1 cubes and cross terms
                wph_reg <= wph_reg + 1'b1;
                if (wph_reg == 2'd0)
                begin
                    uu_reg <= u_reg * u_reg;
                    tt_reg <= t_reg * t_reg;
                end
                else
                begin
                    w_reg[0] <= 32'((w_a + 51'd131072) >> 18);
                    w_reg[1] <= 32'((w_b + 51'd131072) >> 18);
                    w_reg[2] <= 32'((w_c + 51'd131072) >> 18);
                    w_reg[3] <= 32'((w_d + 51'd131072) >> 18);
                end
                bi_reg <= '0;
                bvalid_reg <= 1'b0;
                accx_reg <= '0; accy_reg <= '0; accz_reg <= '0;
            end
            CMD_BLEND_RD:
            begin
                bvalid_reg <= bidx < cnt_reg;
            end
            CMD_BLEND_ACC:
            begin
                if (bvalid_reg)
                begin
                    accx_reg <= accx_reg + prod_x;
                    accy_reg <= accy_reg + prod_y;
                    accz_reg <= accz_reg + prod_z;
                end
                if (bi_reg != 2'd3)
                    bi_reg <= bi_reg + 1'b1;
            end
            default: ;
        endcase
        if (ctl.cmd == CMD_RD_P0)
        begin
            ax_reg <= ax_reg;
        end
        if (ctl.cmd == CMD_RD_P1)
        begin
            ax_reg <= rx_reg; ay_reg <= ry_reg; az_reg <= rz_reg;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.cmd == CMD_FINISH)
        begin
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            ost_reg <= ST_OK;
            if (op_reg == OP_EVAL)
            begin
                if (stat.few)
                begin
                    oy_reg  <= {1'b0, tm_reg};
                    ost_reg <= ST_FEW;
                end
                else
                begin
                    ox_reg <= rnd_sat(accx_reg);
                    oy_reg <= rnd_sat(accy_reg);
                    oz_reg <= rnd_sat(accz_reg);
                end
            end
            else if (drop_reg)
                ost_reg <= ST_FULL;
        end
    end

    assign res_x = ox_reg;
    assign res_y = oy_reg;
    assign res_z = oz_reg;
    assign res_status = ost_reg;
endmodule

/* rtl/core/pbp_ctrl.sv */
// sequencing state machine of the bezier path block
module pbp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  pbp_pkg::stat_t stat,
    output pbp_pkg::ctl_t  ctl
);
    import pbp_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl.cmd    = CMD_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cmd    = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                if (stat.op == OP_CLEAR)
                    ctl.cmd = CMD_CLEAR;
                else if (stat.no_room)
                    ctl.cmd = CMD_DROP;
                else if (stat.op == OP_ADD)
                begin
                    ctl.cmd    = CMD_RD_LAST;
                    state_next = stat.mid ? S_MID : S_NEW;
                end
                else if (stat.op == OP_CLOSE)
                begin
                    ctl.cmd    = CMD_RD_P0;
                    state_next = stat.close_go ? S_RD_P1 : S_SEG;
                end
                else if (!stat.few)
                    state_next = S_DIV;
            end
            S_MID:
            begin
                ctl.cmd    = CMD_PUT_MID;
                state_next = S_NEW;
            end
            S_NEW:
            begin
                ctl.cmd    = CMD_PUT_NEW;
                state_next = S_SEG;
            end
            S_RD_P1:
            begin
                ctl.cmd    = CMD_RD_P1;
                state_next = S_REFL;
            end
            S_REFL:
            begin
                ctl.cmd    = CMD_PUT_REFL;
                state_next = S_P0;
            end
            S_P0:
            begin
                ctl.cmd    = CMD_PUT_P0;
                state_next = S_SEG;
            end
            S_SEG:
            begin
                ctl.cmd    = CMD_SEGCNT;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_WEIGHT;
                else
                    ctl.cmd = CMD_DIV_STEP;
            end
            S_WEIGHT:
            begin
                ctl.cmd    = CMD_WEIGHT;
                state_next = S_RD_LAST;
            end
            S_RD_LAST:
            begin
                ctl.cmd    = CMD_WEIGHT;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                ctl.cmd    = CMD_BLEND_RD;
                state_next = S_BACC;
            end
            S_BACC:
            begin
                ctl.cmd    = CMD_BLEND_ACC;
                state_next = stat.blend_done ? S_FIN : S_BRD;
            end
            S_FIN:
            begin
                ctl.cmd    = CMD_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* rtl/core/piecewise_bezier_path.sv */
// top level of the piecewise cubic bezier path evaluator
//  channel | valid     | ready     | words
//  input   | in_valid  | in_ready  | operation, coord_x/y/z, path_time
//  output  | out_valid | out_ready | out_x/y/z, status
// sequence per word: clear, a dropped word and evaluate on too few points go
// straight to the result; add writes a midpoint first when one is needed, then
// the new point; close appends its two points when it may; evaluate runs the
// bit-serial segment modulo (15 steps), the weight phases and four blend
// read/accumulate pairs on the single store read port.
// reset empties the store at once; a result waits in the output register
// while out_ready is low and no new word is taken meanwhile.
module piecewise_bezier_path #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [30:0]        path_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [1:0]         status
);
    import pbp_pkg::*;
`include "assert_macros.svh"

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    ctl_t  ctl;
    stat_t stat;

    pbp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .ctl(ctl)
    );

    pbp_datapath #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .stat(stat),
        .operation(operation), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .path_time(path_time),
        .res_x(out_x), .res_y(out_y), .res_z(out_z), .res_status(status)
    );

    // checks
    `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_IMPLIES(a_status_range, clk, rst_n, out_valid, status != 2'd3)
endmodule

/* verif/piecewise_bezier_path_tb.sv */
// testbench of the piecewise cubic bezier path block: predicted results against the dut
module piecewise_bezier_path_tb;
    import pbp_pkg::*;

    localparam int NPTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
    } word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [30:0]        path_time;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;

    // predicted path store
    logic signed [31:0] pts_x [NPTS];
    logic signed [31:0] pts_y [NPTS];
    logic signed [31:0] pts_z [NPTS];
    int unsigned        n_pts;
    int unsigned        n_segs;

    word_t expected_words[$];
    int    errors;
    int    idle_cycles;
    bit    rx_idle_on;

    piecewise_bezier_path #(.MAX_POINTS(NPTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .path_time(path_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        if (v < -66'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] floor_mid(logic signed [31:0] a,
                                                     logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return s[32:1];
    endfunction

    function automatic logic signed [31:0] point_at(int unsigned k, int axis);
        if (k >= n_pts)
            return 32'sd0;
        case (axis)
            0: return pts_x[k];
            1: return pts_y[k];
            default: return pts_z[k];
        endcase
    endfunction

    function automatic void push_point(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
        pts_x[n_pts] = x;
        pts_y[n_pts] = y;
        pts_z[n_pts] = z;
        n_pts++;
    endfunction

    // path model: updates the store and returns the expected word
    function automatic word_t path_step(logic [1:0] op, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z,
                                        logic [30:0] tm);
        word_t r;
        logic [63:0] t, u;
        logic [63:0] w [4];
        logic signed [65:0] v;
        logic signed [127:0] acc;
        int unsigned seg, p;
        bit mid, go;
        r = '0;
        case (op)
            OP_ADD:
            begin
                mid = (n_pts != 0) && (n_pts % 3 == 0);
                if (n_pts + (mid ? 2 : 1) > NPTS)
                    r.st = ST_FULL;
                else
                begin
                    if (mid)
                    begin
                        p = n_pts - 1;
                        push_point(floor_mid(x, pts_x[p]), floor_mid(y, pts_y[p]),
                                   floor_mid(z, pts_z[p]));
                    end
                    push_point(x, y, z);
                    if (n_pts <= 4) n_segs = 1;
                    else if (n_pts % 3 == 0) n_segs = n_pts / 3 - 1;
                    else n_segs = n_pts / 3;
                end
            end
            OP_CLOSE:
            begin
                go = (n_pts >= 2) && ((n_pts + 1) % 3 == 0);
                if (go && n_pts + 2 > NPTS)
                    r.st = ST_FULL;
                else
                begin
                    if (go)
                    begin
                        push_point(clamp32(2 * 66'(pts_x[0]) - 66'(pts_x[1])),
                                   clamp32(2 * 66'(pts_y[0]) - 66'(pts_y[1])),
                                   clamp32(2 * 66'(pts_z[0]) - 66'(pts_z[1])));
                        push_point(pts_x[0], pts_y[0], pts_z[0]);
                    end
                    n_segs = (n_pts <= 4) ? 1 : n_pts / 3;
                end
            end
            OP_CLEAR:
            begin
                n_pts = 0;
                n_segs = 0;
            end
            default:
            begin
                if (n_pts < 4)
                begin
                    r.y = 32'(tm);
                    r.st = ST_FEW;
                end
                else
                begin
                    t = 64'(tm[15:0]);
                    u = 64'd65536 - t;
                    seg = (n_segs != 0) ? (int'(tm[30:16]) % n_segs) : 0;
                    w[0] = (u * u * u + 64'd131072) >> 18;
                    w[1] = (3 * u * u * t + 64'd131072) >> 18;
                    w[2] = (3 * u * t * t + 64'd131072) >> 18;
                    w[3] = (t * t * t + 64'd131072) >> 18;
                    for (int a = 0; a < 3; a++)
                    begin
                        acc = 0;
                        for (int i = 0; i < 4; i++)
                            acc += 128'(point_at(seg * 3 + i, a)) * $signed({1'b0, w[i]});
                        acc = (acc + 128'sd536870912) >>> 30;
                        v = clamp32(66'(acc > 128'sd4294967296 ? 128'sd4294967296 :
                                        acc < -128'sd4294967296 ? -128'sd4294967296 : acc));
                        case (a)
                            0: r.x = v[31:0];
                            1: r.y = v[31:0];
                            default: r.z = v[31:0];
                        endcase
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 8)) << 16) - 32'sh40000;
            default: return $signed($urandom());
        endcase
    endfunction

    // send one word and queue its prediction
    task automatic send_word(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic [30:0] tm, bit gaps = 1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        path_time <= tm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_words.insert(expected_words.size(), path_step(op, x, y, z, tm));
    endtask

    task automatic add_rand();
        send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(), 31'($urandom()));
    endtask

    task automatic eval_rand();
        logic [30:0] tm;
        tm = 31'($urandom());
        if ($urandom_range(0, 3) != 0)
            tm[30:16] = 15'($urandom_range(0, 30));
        if ($urandom_range(0, 9) == 0)
            tm[15:0] = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
        send_word(OP_EVAL, rand_coord(), rand_coord(), rand_coord(), tm);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // extremes, empty store, single segment and close
    task automatic test_directed();
        send_word(OP_EVAL, 0, 0, 0, 31'h7fffffff);
        send_word(OP_CLOSE, 0, 0, 0, 0);
        send_word(OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        send_word(OP_ADD, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
        send_word(OP_EVAL, 0, 0, 0, 31'h0001_8000);
        send_word(OP_ADD, 32'sh10000, -32'sh10000, 32'sh7fffffff, 0);
        send_word(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0);
        send_word(OP_EVAL, 0, 0, 0, 31'h0000_0000);
        send_word(OP_EVAL, 0, 0, 0, 31'h0000_ffff);
        send_word(OP_EVAL, 0, 0, 0, 31'h7fff_8000);
        send_word(OP_ADD, -32'sh1, 32'sh3, 32'sh80000000, 0);
        send_word(OP_EVAL, 0, 0, 0, 31'h0001_4000);
        send_word(OP_CLOSE, 0, 0, 0, 0);
        send_word(OP_ADD, 32'sh20000, 32'sh30000, 32'sh40000, 0);
        send_word(OP_CLOSE, 0, 0, 0, 0);
        send_word(OP_EVAL, 0, 0, 0, 31'h0002_2000);
        send_word(OP_EVAL, 0, 0, 0, 31'h0005_c000);
        send_word(OP_CLEAR, 0, 0, 0, 0);
        send_word(OP_EVAL, 0, 0, 0, 31'h1234_5678);
    endtask

    // fill to capacity so adds are dropped, with a close sent near the limit
    task automatic test_full_store();
        send_word(OP_CLEAR, 0, 0, 0, 0);
        while (n_pts < NPTS - 1)
            send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(), 0, 0);
        send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(), 0);
        send_word(OP_CLOSE, 0, 0, 0, 0);
        send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(), 0);
        repeat (8) eval_rand();
        send_word(OP_CLEAR, 0, 0, 0, 0);
        while (n_pts < NPTS - 2)
            send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(), 0, 0);
        send_word(OP_CLOSE, 0, 0, 0, 0);
        send_word(OP_ADD, rand_coord(), rand_coord(), rand_coord(), 0);
        eval_rand();
    endtask

    // random paths: build, maybe close, evaluate, with some noise
    task automatic test_random_paths();
        int sent;
        int len;
        sent = 0;
        while (sent < 1420)
        begin
            send_word(OP_CLEAR, 0, 0, 0, 0);
            sent++;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 50) : $urandom_range(1, 14);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    eval_rand();
                else if ($urandom_range(0, 14) == 0)
                    send_word(OP_CLOSE, 0, 0, 0, 31'($urandom()));
                else
                    add_rand();
                sent++;
            end
            if ($urandom_range(0, 1) != 0)
            begin
                send_word(OP_CLOSE, 0, 0, 0, 0);
                sent++;
            end
            for (int i = $urandom_range(2, 10); i > 0; i--)
            begin
                eval_rand();
                sent++;
            end
        end
    endtask

    // result receiver with random stalls while rx_idle_on is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_idle_on)
            out_ready <= ($urandom_range(0, 2) != 0) || ($urandom_range(0, 30) == 0);
        else
            out_ready <= 1'b1;
    end

    // stall pattern switch
    initial
    begin
        rx_idle_on = 1'b1;
        forever
        begin
            repeat ($urandom_range(200, 2000)) @(posedge clk);
            rx_idle_on = ~rx_idle_on;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word x=%h y=%h z=%h status=%0d",
                         $time, out_x, out_y, out_z, status);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_x !== e.x)
                begin
                    $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
                    errors++;
                end
                if (out_y !== e.y)
                begin
                    $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
                    errors++;
                end
                if (out_z !== e.z)
                begin
                    $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("piecewise_bezier_path_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_CLEAR;
        coord_x = 0;
        coord_y = 0;
        coord_z = 0;
        path_time = 0;
        errors = 0;
        idle_cycles = 0;
        n_pts = 0;
        n_segs = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        test_random_paths();
        drain();
        if (errors == 0)
            $display("piecewise_bezier_path_tb OK");
        else
            $display("piecewise_bezier_path_tb NOT OK");
        $finish;
    end
endmodule

/* piecewise_bezier_path.f */
+incdir+rtl/core
rtl/core/pbp_pkg.sv
rtl/core/pbp_datapath.sv
rtl/core/pbp_ctrl.sv
rtl/core/piecewise_bezier_path.sv
verif/piecewise_bezier_path_tb.sv
